[design/lahs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan package
// Shared widths, mode codes, register indexes and saturation functions.
// ----------------------------------------------------------------------------
package lahs_pkg;
   localparam int MaxPatternDefault   = 1024;
   localparam int AlphabetSizeDefault = 128;
   localparam int PositionBitsDefault = 24;

   localparam int ScoreW = 18;
   localparam int GapW   = 19;
   localparam int PenW   = 9;
   localparam int ProfW  = 8;
   localparam int SymW   = 7;
   localparam int PidxW  = 10;
   localparam int PlenW  = 11;
   localparam int CsrIdxW = 2;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [CsrIdxW-1:0] REG_GAP_OPEN = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_GAP_EXT  = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_MIN      = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_PLEN     = 2'd3;

   localparam logic signed [GapW-1:0] GapMin = 19'sh40000;
   localparam logic signed [GapW-1:0] GapMax = 19'sh3FFFF;

   function automatic logic signed [GapW-1:0] sat_gap(input logic signed [GapW+1:0] v);
      if (v < $signed({{2{GapMin[GapW-1]}}, GapMin})) begin
         return GapMin;
      end else if (v > $signed({2'b00, GapMax})) begin
         return GapMax;
      end
      return v[GapW-1:0];
   endfunction

   function automatic logic [ScoreW-1:0] sat_score(input logic signed [GapW+1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > 21'sd262143) begin
         return {ScoreW{1'b1}};
      end
      return v[ScoreW-1:0];
   endfunction
endpackage

[design/lahs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan channels
// Valid/ready channel interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
interface lahs_req_if;
   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [6:0]       symbol;
   logic [9:0]       pattern_index;
   logic signed [7:0] profile_score;
   modport source (output valid, mode, symbol, pattern_index, profile_score, input ready);
   modport sink   (input valid, mode, symbol, pattern_index, profile_score, output ready);
endinterface

interface lahs_rsp_if;
   logic        valid;
   logic        ready;
   logic [17:0] hit_score;
   logic [23:0] ref_start;
   logic [23:0] ref_length;
   modport source (output valid, hit_score, ref_start, ref_length, input ready);
   modport sink   (input valid, hit_score, ref_start, ref_length, output ready);
endinterface

interface lahs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [17:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/lahs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan RAM
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lahs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

[design/lahs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan cell
// One pattern position: holds its H, F and start, its profile column, and
// computes one cell per row, passing diagonal, horizontal gap and row maximum
// to the next cell through its stage A and output registers.
// ----------------------------------------------------------------------------
module lahs_cell
   import lahs_pkg::*;
#(
   parameter int AlphabetSize = 128,
   parameter int PositionBits = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          load_we,
   input  logic [$clog2(AlphabetSize)-1:0] load_sym,
   input  logic signed [ProfW-1:0]       load_score,
   input  logic signed [PenW-1:0]        gap_open,
   input  logic signed [PenW-1:0]        gap_ext,
   input  logic                          in_act,
   input  logic                          in_last,
   input  logic                          in_symok,
   input  logic [$clog2(AlphabetSize)-1:0] in_sym,
   input  logic [PositionBits-1:0]       in_row,
   input  logic [ScoreW-1:0]             in_diag,
   input  logic [PositionBits-1:0]       in_dstart,
   input  logic [PositionBits-1:0]       in_lstart,
   input  logic signed [GapW-1:0]        in_horiz,
   input  logic [ScoreW-1:0]             in_rmax,
   input  logic [PositionBits-1:0]       in_bstart,
   output logic                          out_act,
   output logic                          out_last,
   output logic                          out_symok,
   output logic [$clog2(AlphabetSize)-1:0] out_sym,
   output logic [PositionBits-1:0]       out_row,
   output logic [ScoreW-1:0]             out_diag,
   output logic [PositionBits-1:0]       out_dstart,
   output logic [PositionBits-1:0]       out_lstart,
   output logic signed [GapW-1:0]        out_horiz,
   output logic [ScoreW-1:0]             out_rmax,
   output logic [PositionBits-1:0]       out_bstart
);
   localparam int AW = $clog2(AlphabetSize);

   // Stage A: profile read issued; stage B: cell update.
   logic                    a_act_ff, a_last_ff, a_symok_ff;
   logic [PositionBits-1:0] a_row_ff, a_dstart_ff, a_lstart_ff, a_bstart_ff;
   logic [ScoreW-1:0]       a_diag_ff, a_rmax_ff;
   logic signed [GapW-1:0]  a_horiz_ff;
   logic [AW-1:0]           a_sym_ff;
   logic signed [ProfW-1:0] prof_rd;

   logic [ScoreW-1:0]       h_ff;
   logic signed [GapW-1:0]  f_ff;
   logic [PositionBits-1:0] st_ff;

   logic                    o_act_ff, o_last_ff, o_symok_ff;
   logic [AW-1:0]           o_sym_ff;
   logic [PositionBits-1:0] o_row_ff, o_dstart_ff, o_lstart_ff, o_bstart_ff;
   logic [ScoreW-1:0]       o_diag_ff, o_rmax_ff;
   logic signed [GapW-1:0]  o_horiz_ff;

   logic [ScoreW-1:0]       h_in, m_in, rmax_in;
   logic [PositionBits-1:0] st_in, bstart_in;
   logic signed [GapW-1:0]  f_in, horiz_in;

   lahs_ram #(.Width(ProfW), .Depth(AlphabetSize)) u_prof (
      .clock(clock), .we(load_we), .addr(load_we ? load_sym : in_sym),
      .wdata(load_score), .rdata(prof_rd)
   );

   always_comb begin
      logic signed [GapW+1:0] sum, hg, t;
      logic signed [ProfW-1:0] sc;
      sc = a_symok_ff ? prof_rd : '0;
      sum = $signed({3'b000, a_diag_ff}) + (GapW+2)'(sc);
      m_in = sat_score(sum);
      st_in = a_dstart_ff;
      if (m_in == '0) begin
         st_in = a_row_ff;
      end
      rmax_in = a_rmax_ff;
      bstart_in = a_bstart_ff;
      if (m_in >= a_rmax_ff) begin
         rmax_in = m_in;
         bstart_in = st_in;
      end
      h_in = m_in;
      if ($signed({2'b00, h_in}) < f_ff) begin
         h_in = f_ff[ScoreW-1:0];
         st_in = st_ff;
      end
      if ($signed({2'b00, h_in}) < a_horiz_ff) begin
         h_in = a_horiz_ff[ScoreW-1:0];
         st_in = a_lstart_ff;
      end
      hg = $signed({3'b000, h_in}) + (GapW+2)'(gap_open);
      t = (GapW+2)'(sat_gap((GapW+2)'(a_horiz_ff) + (GapW+2)'(gap_ext)));
      if (hg > t) begin
         t = hg;
      end
      horiz_in = sat_gap(t);
      t = (GapW+2)'(sat_gap((GapW+2)'(f_ff) + (GapW+2)'(gap_ext)));
      if (hg > t) begin
         t = hg;
      end
      f_in = sat_gap(t);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         a_act_ff <= 1'b0;
         o_act_ff <= 1'b0;
         h_ff <= '0;
         f_ff <= '0;
         st_ff <= '0;
      end else begin
         a_act_ff <= in_act;
         o_act_ff <= a_act_ff;
         if (a_act_ff) begin
            h_ff <= h_in;
            f_ff <= f_in;
            st_ff <= st_in;
         end
      end
      a_last_ff <= in_last;  a_symok_ff <= in_symok; a_sym_ff <= in_sym;
      a_row_ff <= in_row;    a_diag_ff <= in_diag;   a_dstart_ff <= in_dstart;
      a_lstart_ff <= in_lstart; a_horiz_ff <= in_horiz;
      a_rmax_ff <= in_rmax;  a_bstart_ff <= in_bstart;
      o_last_ff <= a_last_ff; o_symok_ff <= a_symok_ff; o_sym_ff <= a_sym_ff;
      o_row_ff <= a_row_ff;  o_diag_ff <= h_ff;      o_dstart_ff <= st_ff;
      o_lstart_ff <= st_in;  o_horiz_ff <= horiz_in;
      o_rmax_ff <= rmax_in;  o_bstart_ff <= bstart_in;
   end

   assign out_act = o_act_ff;
   assign out_last = o_last_ff;
   assign out_symok = o_symok_ff;
   assign out_sym = o_sym_ff;
   assign out_row = o_row_ff;
   assign out_diag = o_diag_ff;
   assign out_dstart = o_dstart_ff;
   assign out_lstart = o_lstart_ff;
   assign out_horiz = o_horiz_ff;
   assign out_rmax = o_rmax_ff;
   assign out_bstart = o_bstart_ff;
endmodule

[design/local_alignment_hit_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan unit
// Affine-gap local alignment of a pattern profile against a search stream.
//
// Requests arrive on req (mode, symbol, pattern_index, profile_score).
// A load request writes one profile entry in the cell of its pattern position.
// A clear request resets every cell and the row counter. A search request
// enters a chain of MaxPattern cells, one per pattern position; each cell
// passes the row through its stage A and output registers, and a row's hit
// is registered into the rsp output when the row leaves the last cell of
// the pattern. One search request is in flight at a time: no request is
// accepted until the row has left the last cell.
// A hit is held in an output register until taken, and no request is
// accepted while it waits.
// Register writes on csr are accepted at any time.
// Reset clears cells and the row counter and sets the registers to their
// defaults; profile entries stay undefined until loaded.
// ----------------------------------------------------------------------------
module local_alignment_hit_scan_unit
   import lahs_pkg::*;
#(
   parameter int MaxPattern   = MaxPatternDefault,
   parameter int AlphabetSize = AlphabetSizeDefault,
   parameter int PositionBits = PositionBitsDefault
) (
   input logic       clock,
   input logic       reset,
   lahs_req_if.sink  req,
   lahs_rsp_if.source rsp,
   lahs_csr_if.sink  csr
);
   localparam int AW = $clog2(AlphabetSize);
   localparam int PW = $clog2(MaxPattern);

   logic signed [PenW-1:0]  gap_open_ff, gap_ext_ff;
   logic [ScoreW-1:0]       min_score_ff;
   logic [PlenW-1:0]        plen_ff;
   logic [PositionBits-1:0] row_ff;
   logic                    busy_ff;
   logic                    rv_ff;
   logic [ScoreW-1:0]       rs_ff;
   logic [PositionBits-1:0] rst_ff, rl_ff;

   logic [MaxPattern:0]     c_act, c_last, c_symok;
   logic [AW-1:0]           c_sym [MaxPattern+1];
   logic [PositionBits-1:0] c_row [MaxPattern+1], c_dst [MaxPattern+1];
   logic [PositionBits-1:0] c_lst [MaxPattern+1], c_bst [MaxPattern+1];
   logic [ScoreW-1:0]       c_diag [MaxPattern+1], c_rmax [MaxPattern+1];
   logic signed [GapW-1:0]  c_hz [MaxPattern+1];

   logic                    acc, is_search, clear, done, last_hit;
   logic [PositionBits-1:0] row_next, done_row, done_bst;
   logic [ScoreW-1:0]       done_rmax;
   logic [PW:0]             plen_eff;

   assign req.ready = !busy_ff && !rv_ff;
   assign acc = req.valid && req.ready;
   assign is_search = acc && req.mode == MODE_SEARCH;
   assign clear = acc && req.mode == MODE_CLEAR;
   assign csr.ready = 1'b1;
   assign row_next = row_ff + PositionBits'(1);

   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = (PW+1)'(1);
      end else if ({{(PW+1 > PlenW ? PW+1-PlenW : 0){1'b0}}, plen_ff} > MaxPattern) begin
         plen_eff = (PW+1)'(MaxPattern);
      end else begin
         plen_eff = (PW+1)'(plen_ff);
      end
   end

   assign c_act[0] = is_search;
   assign c_symok[0] = ({{(AW > SymW ? AW-SymW : 0){1'b0}}, req.symbol} < AlphabetSize);
   assign c_sym[0] = AW'(req.symbol);
   assign c_row[0] = row_next;
   assign c_diag[0] = '0;
   assign c_dst[0] = row_ff;
   assign c_lst[0] = row_next;
   assign c_hz[0] = '0;
   assign c_rmax[0] = '0;
   assign c_bst[0] = row_next;
   assign c_last[0] = 1'b0;

   for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
      logic lw, lastj;
      assign lw = acc && req.mode == MODE_LOAD && req.pattern_index == PidxW'(j)
                  && c_symok[0] && (j < 1024);
      assign lastj = plen_eff == (PW+1)'(j + 1);
      lahs_cell #(.AlphabetSize(AlphabetSize), .PositionBits(PositionBits)) u_cell (
         .clock(clock), .reset(reset), .clear(clear), .load_we(lw),
         .load_sym(AW'(req.symbol)), .load_score(req.profile_score),
         .gap_open(gap_open_ff), .gap_ext(gap_ext_ff),
         .in_act(c_act[j] && !c_last[j]), .in_last(lastj), .in_symok(c_symok[j]),
         .in_sym(c_sym[j]), .in_row(c_row[j]), .in_diag(c_diag[j]),
         .in_dstart(c_dst[j]), .in_lstart(c_lst[j]), .in_horiz(c_hz[j]),
         .in_rmax(c_rmax[j]), .in_bstart(c_bst[j]),
         .out_act(c_act[j+1]), .out_last(c_last[j+1]), .out_symok(c_symok[j+1]),
         .out_sym(c_sym[j+1]), .out_row(c_row[j+1]), .out_diag(c_diag[j+1]),
         .out_dstart(c_dst[j+1]), .out_lstart(c_lst[j+1]), .out_horiz(c_hz[j+1]),
         .out_rmax(c_rmax[j+1]), .out_bstart(c_bst[j+1])
      );
   end

   always_comb begin
      done = 1'b0;
      done_rmax = '0;
      done_bst = '0;
      done_row = '0;
      for (int k = 1; k <= MaxPattern; k++) begin
         if (c_act[k] && c_last[k]) begin
            done = 1'b1;
            done_rmax = c_rmax[k];
            done_bst = c_bst[k];
            done_row = c_row[k];
         end
      end
   end
   assign last_hit = done && done_rmax >= min_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff <= -9'sd1;
         gap_ext_ff <= -9'sd1;
         min_score_ff <= '0;
         plen_ff <= PlenW'(1);
         row_ff <= '0;
         busy_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               REG_GAP_OPEN: gap_open_ff <= csr.data[PenW-1:0];
               REG_GAP_EXT:  gap_ext_ff <= csr.data[PenW-1:0];
               REG_MIN:      min_score_ff <= csr.data[ScoreW-1:0];
               REG_PLEN:     plen_ff <= csr.data[PlenW-1:0];
               default: ;
            endcase
         end
         if (clear) begin
            row_ff <= '0;
         end else if (is_search) begin
            row_ff <= row_next;
            busy_ff <= 1'b1;
         end
         if (done) begin
            busy_ff <= 1'b0;
         end
         if (last_hit) begin
            rv_ff <= 1'b1;
         end else if (rsp.ready) begin
            rv_ff <= 1'b0;
         end
      end
      if (last_hit) begin
         rs_ff <= done_rmax;
         rst_ff <= done_bst;
         rl_ff <= done_row - done_bst;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.hit_score = rs_ff;
   assign rsp.ref_start = 24'(rst_ff);
   assign rsp.ref_length = 24'(rl_ff);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("request taken while a row is in flight");
   a_hit_after_done: assert property (@(posedge clock) disable iff (reset)
      last_hit |=> rsp.valid) else $error("hit lost");
   a_one_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0(c_act & c_last)) else $error("two rows finished together");
endmodule

[dv/local_alignment_hit_scan_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment hit scan unit testbench
// Drives profile loads, clears and search symbols into the block under
// several gap and threshold settings. A scoreboard class models the
// affine-gap cells and checks every hit in order.
// ----------------------------------------------------------------------------
module local_alignment_hit_scan_unit_tb;
   import lahs_pkg::*;

   localparam int NPat = 1024;
   localparam int NSym = 128;
   localparam int SMax = 262143;
   localparam int WatchLimit = 200000;
   localparam int LongLen = 192;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [17:0] hit_score;
      logic [23:0] ref_start;
      logic [23:0] ref_length;
   } hit_type;

   class hit_scoreboard;
      int profile[NSym*NPat];
      int cell_h[NPat];
      int cell_f[NPat];
      int cell_st[NPat];
      int rows;
      int open_pen, ext_pen, threshold, plen;
      hit_type pending[$];
      int mismatches, hits;

      function new();
         open_pen = -1; ext_pen = -1; threshold = 0; plen = 1;
         clear_cells();
      endfunction

      function void clear_cells();
         for (int j = 0; j < NPat; j++) begin
            cell_h[j] = 0; cell_f[j] = 0; cell_st[j] = 0;
         end
         rows = 0;
      endfunction

      function int clampv(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void write_reg(logic [1:0] idx, logic [17:0] d);
         case (idx)
            REG_GAP_OPEN: open_pen = int'($signed(d[8:0]));
            REG_GAP_EXT: ext_pen = int'($signed(d[8:0]));
            REG_MIN: threshold = int'(d);
            REG_PLEN: plen = int'(d[10:0]);
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] m, logic [6:0] s, logic [9:0] pi,
                                 logic signed [7:0] ps);
         int n, row, dstart, lstart, bstart, diag, horiz, rmax, sc, h, st, f, hg;
         hit_type r;
         if (m == MODE_LOAD) begin
            profile[int'(s)*NPat+int'(pi)] = int'(ps);
         end else if (m == MODE_CLEAR) begin
            clear_cells();
         end else if (m == MODE_SEARCH) begin
            n = plen == 0 ? 1 : (plen > NPat ? NPat : plen);
            row = (rows + 1) & 24'hFFFFFF;
            dstart = (row - 1) & 24'hFFFFFF;
            lstart = row; bstart = row;
            diag = 0; horiz = 0; rmax = 0;
            rows = row;
            for (int j = 0; j < n; j++) begin
               sc = profile[int'(s)*NPat+j];
               h = clampv(diag + sc, 0, SMax);
               st = dstart;
               f = cell_f[j];
               if (h <= 0) begin h = 0; st = row; end
               if (h >= rmax) begin rmax = h; bstart = st; end
               if (h < f) begin h = f; st = cell_st[j]; end
               if (h < horiz) begin h = horiz; st = lstart; end
               h = clampv(h, 0, SMax);
               diag = cell_h[j]; dstart = cell_st[j];
               cell_h[j] = h; cell_st[j] = st; lstart = st;
               hg = h + open_pen;
               horiz = clampv(horiz + ext_pen, -262144, 262143);
               if (hg > horiz) horiz = hg;
               horiz = clampv(horiz, -262144, 262143);
               f = clampv(f + ext_pen, -262144, 262143);
               if (hg > f) f = hg;
               cell_f[j] = clampv(f, -262144, 262143);
            end
            if (rmax >= threshold) begin
               r.hit_score = 18'(rmax);
               r.ref_start = 24'(bstart);
               r.ref_length = 24'(row - bstart);
               pending.push_back(r);
            end
         end
      endfunction

      function void check_hit(hit_type got);
         hit_type want;
         hits++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected hit %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.hit_score !== want.hit_score || got.ref_start !== want.ref_start
             || got.ref_length !== want.ref_length) begin
            mismatches++;
            if (mismatches <= 10) $display("hit mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   lahs_req_if req ();
   lahs_rsp_if rsp ();
   lahs_csr_if csr ();

   local_alignment_hit_scan_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #10 clock = ~clock;

   hit_scoreboard sb = new();
   int idle_pct = 8;
   int watch = 0;
   int requests = 0;
   int searches = 0;
   bit loaded[NSym];

   initial begin
      req.valid = 0; req.mode = 0; req.symbol = 0; req.pattern_index = 0;
      req.profile_score = 0;
      csr.valid = 0; csr.index = 0; csr.data = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            sb.check_hit({rsp.hit_score, rsp.ref_start, rsp.ref_length});
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)
             || (csr.valid && csr.ready)) begin
            watch <= 0;
         end else begin
            watch <= watch + 1;
         end
         if (watch >= WatchLimit) begin
            $display("watchdog expired");
            $display("local_alignment_hit_scan_unit_tb: done, errors");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= idle_pct);
   end

   task automatic send(logic [1:0] m, logic [6:0] s, logic [9:0] pi, logic signed [7:0] ps);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1; req.mode <= m; req.symbol <= s;
      req.pattern_index <= pi; req.profile_score <= ps;
      do @(posedge clock); while (!req.ready);
      sb.note_request(m, s, pi, ps);
      requests++;
      if (m == MODE_SEARCH) searches++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (2 * NPat + 20) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [17:0] d);
      csr.valid <= 1'b1; csr.index <= idx; csr.data <= d;
      do @(posedge clock); while (!csr.ready);
      sb.write_reg(idx, d);
      @(negedge clock);
   endtask

   task automatic setup(int go, int ge, int ms, int pl);
      drain();
      write_csr(REG_GAP_OPEN, 18'(go & 'h1FF));
      write_csr(REG_GAP_EXT, 18'(ge & 'h1FF));
      write_csr(REG_MIN, 18'(ms));
      write_csr(REG_PLEN, 18'(pl));
      csr.valid <= 1'b0;
   endtask

   task automatic load_rows(int pl, int lo, int hi);
      for (int s = 0; s < NSym; s += 1 + $urandom_range(40)) begin
         for (int j = 0; j < pl; j++) begin
            send(MODE_LOAD, 7'(s), 10'(j), 8'($urandom_range(hi - lo) + lo));
         end
         loaded[s] = 1;
      end
   endtask

   function automatic logic [6:0] pick_sym();
      int s;
      do s = $urandom_range(NSym - 1); while (!loaded[s]);
      return 7'(s);
   endfunction

   task automatic search_run(int count, int pl);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(19))
            0: send(MODE_CLEAR, 7'($urandom), 10'($urandom), 8'($urandom));
            1: send(MODE_SPARE, 7'($urandom), 10'($urandom), 8'($urandom));
            2: send(MODE_LOAD, pick_sym(), 10'($urandom_range(pl - 1)), 8'($urandom));
            default: send(MODE_SEARCH, pick_sym(), 10'($urandom), 8'($urandom));
         endcase
      end
   endtask

   initial begin
      int pl;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes of the load fields, every mode, a length of zero.
      send(MODE_LOAD, 7'd127, 10'd1023, 8'sd127);
      send(MODE_LOAD, 7'd0, 10'd0, -8'sd128);
      send(MODE_LOAD, 7'd127, 10'd0, 8'sd127);
      send(MODE_LOAD, 7'd1, 10'd0, 8'sd5);
      send(MODE_SEARCH, 7'd127, 10'd1023, 8'sd0);
      send(MODE_SEARCH, 7'd127, 10'd0, 8'sd0);
      send(MODE_SEARCH, 7'd0, 10'd0, 8'sd0);
      send(MODE_SPARE, 7'h7F, 10'h3FF, -8'sd1);
      send(MODE_SEARCH, 7'd1, 10'd0, 8'sd0);
      send(MODE_CLEAR, 7'd0, 10'd0, 8'sd0);
      send(MODE_SEARCH, 7'd1, 10'd0, 8'sd0);
      setup(0, 0, 0, 0);
      send(MODE_SEARCH, 7'd127, 10'd0, 8'sd0);
      send(MODE_SEARCH, 7'd1, 10'd0, 8'sd0);

      // Long pattern with maximum scores and heavy penalties.
      setup(-255, -255, 200, LongLen);
      for (int j = 0; j < LongLen; j++) send(MODE_LOAD, 7'd127, 10'(j), 8'sd127);
      send(MODE_CLEAR, 7'd0, 10'd0, 8'sd0);
      repeat (4) send(MODE_SEARCH, 7'd127, 10'd0, 8'sd0);

      // Random phases over small patterns and varied settings.
      for (int ph = 0; ph < 7; ph++) begin
         pl = 1 + $urandom_range(ph < 4 ? 6 : 24);
         case (ph)
            0: setup(-1, -1, 0, pl);
            1: setup(-255, -1, $urandom_range(40), pl);
            2: setup(-1, -255, $urandom_range(200), pl);
            3: setup(-$urandom_range(255) - 1, -$urandom_range(255) - 1, 1, pl);
            4: setup(-$urandom_range(30) - 1, -$urandom_range(10) - 1, 262143, pl);
            default: setup(-$urandom_range(20) - 1, -$urandom_range(5) - 1,
                           $urandom_range(100), pl);
         endcase
         idle_pct = (ph == 5) ? 0 : 8;
         foreach (loaded[s]) loaded[s] = 0;
         load_rows(pl, -128, 127);
         send(MODE_CLEAR, 7'd0, 10'd0, 8'sd0);
         search_run(40, pl);
         if (ph == 2) drain();
      end

      drain();
      $display("covered %0d requests, %0d searches, %0d hits over several settings",
               requests, searches, sb.hits);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("local_alignment_hit_scan_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches, %0d hits missing", sb.mismatches, sb.pending.size());
         $display("local_alignment_hit_scan_unit_tb: done, errors");
      end
      $finish;
   end
endmodule
